// ===== design/rtcsn_pkg.sv =====
package rtcsn_pkg;

  localparam int BYTE_W = 8;
  localparam int YEAR_W = 16;
  localparam int REF_YEAR_W = 14;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CENTURY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REF_YEAR = 1'b1;

  localparam logic [REF_YEAR_W-1:0] REF_YEAR_RESET = 14'd2015;

  // status register b bits
  localparam int SB_BINARY_BIT = 2;
  localparam int SB_24HOUR_BIT = 1;

  localparam logic [BYTE_W-1:0] HOURS_PER_DAY = 8'd24;
  localparam logic [BYTE_W-1:0] PM_OFFSET = 8'd12;
  localparam logic [7:0] CENTURY_SPAN = 8'd100;

  // divide by 100 through a reciprocal: floor(x * 5243 / 2^19) for x < 2^14
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;

  // one clean snapshot that matched the kept one
  typedef struct packed {
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] minute;
    logic [BYTE_W-1:0] hour;
    logic [BYTE_W-1:0] day;
    logic [BYTE_W-1:0] month;
    logic [BYTE_W-1:0] year;
    logic [BYTE_W-1:0] century;
    logic [BYTE_W-1:0] status_b;
  } job_t;

endpackage

// ===== design/rtcsn_in_if.sv =====
interface rtcsn_in_if;
  import rtcsn_pkg::*;

  logic              valid;
  logic              ready;
  logic              update_busy;
  logic [BYTE_W-1:0] raw_second;
  logic [BYTE_W-1:0] raw_minute;
  logic [BYTE_W-1:0] raw_hour;
  logic [BYTE_W-1:0] raw_day;
  logic [BYTE_W-1:0] raw_month;
  logic [BYTE_W-1:0] raw_year;
  logic [BYTE_W-1:0] raw_century;
  logic [BYTE_W-1:0] status_b;

  modport source (
    output valid, update_busy, raw_second, raw_minute, raw_hour, raw_day,
           raw_month, raw_year, raw_century, status_b,
    input  ready
  );

  modport sink (
    input  valid, update_busy, raw_second, raw_minute, raw_hour, raw_day,
           raw_month, raw_year, raw_century, status_b,
    output ready
  );

endinterface

// ===== design/rtcsn_out_if.sv =====
interface rtcsn_out_if;
  import rtcsn_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_second;
  logic [BYTE_W-1:0] out_minute;
  logic [BYTE_W-1:0] out_hour;
  logic [BYTE_W-1:0] out_day;
  logic [BYTE_W-1:0] out_month;
  logic [YEAR_W-1:0] out_year;

  modport source (
    output valid, out_second, out_minute, out_hour, out_day, out_month, out_year,
    input  ready
  );

  modport sink (
    input  valid, out_second, out_minute, out_hour, out_day, out_month, out_year,
    output ready
  );

endinterface

// ===== design/rtcsn_cfg_if.sv =====
interface rtcsn_cfg_if;
  import rtcsn_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [REF_YEAR_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );

endinterface

// ===== design/rtcsn_front.sv =====
module rtcsn_front (
  input  logic              clk,
  input  logic              rst_n,
  rtcsn_in_if.sink          in_ch,
  input  logic              century_present,
  input  logic              queue_full,
  output logic              push_valid,
  output rtcsn_pkg::job_t   push_job
);
  import rtcsn_pkg::*;

  logic              kept_valid_r, kept_valid_nxt;
  logic [BYTE_W-1:0] kept_second_r;
  logic [BYTE_W-1:0] kept_minute_r;
  logic [BYTE_W-1:0] kept_hour_r;
  logic [BYTE_W-1:0] kept_day_r;
  logic [BYTE_W-1:0] kept_month_r;
  logic [BYTE_W-1:0] kept_year_r;
  logic [BYTE_W-1:0] kept_century_r;
  logic              accept;
  logic              clean;
  logic              match;
  logic              load_kept;

  // accept whenever the queue has a free slot
  assign in_ch.ready = !queue_full;
  assign accept = in_ch.valid && in_ch.ready;
  assign clean = accept && !in_ch.update_busy;

  // compare against the kept snapshot, century only when the register exists
  assign match = kept_valid_r
              && kept_second_r == in_ch.raw_second
              && kept_minute_r == in_ch.raw_minute
              && kept_hour_r == in_ch.raw_hour
              && kept_day_r == in_ch.raw_day
              && kept_month_r == in_ch.raw_month
              && kept_year_r == in_ch.raw_year
              && (!century_present || kept_century_r == in_ch.raw_century);

  assign load_kept = clean && !match;
  assign push_valid = clean && match;

  always_comb begin
    push_job.second = in_ch.raw_second;
    push_job.minute = in_ch.raw_minute;
    push_job.hour = in_ch.raw_hour;
    push_job.day = in_ch.raw_day;
    push_job.month = in_ch.raw_month;
    push_job.year = in_ch.raw_year;
    push_job.century = in_ch.raw_century;
    push_job.status_b = in_ch.status_b;
  end

  // a mismatch keeps the new snapshot, a match consumes the kept one
  always_comb begin
    kept_valid_nxt = kept_valid_r;
    if (clean) begin
      kept_valid_nxt = !match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_valid_r <= 1'b0;
    end else begin
      kept_valid_r <= kept_valid_nxt;
    end
  end

  // kept snapshot bytes
  always_ff @(posedge clk) begin
    if (load_kept) begin
      kept_second_r <= in_ch.raw_second;
      kept_minute_r <= in_ch.raw_minute;
      kept_hour_r <= in_ch.raw_hour;
      kept_day_r <= in_ch.raw_day;
      kept_month_r <= in_ch.raw_month;
      kept_year_r <= in_ch.raw_year;
      kept_century_r <= in_ch.raw_century;
    end
  end

endmodule

// ===== design/rtcsn_queue.sv =====
module rtcsn_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  rtcsn_pkg::job_t push_job,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rtcsn_pkg::job_t pop_job
);
  import rtcsn_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign full = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job = slots_r[rd_ptr_r];
  assign push = push_valid && !full;
  assign pop = pop_valid && pop_ready;

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  // occupancy stays within the slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");

  // the front never offers a transaction into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !full)
    else $error("push while queue full");

  // a push into an empty queue shows at the head next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (push && count_r == '0) |=> pop_valid)
    else $error("pushed entry not visible");

endmodule

// ===== design/rtcsn_back.sv =====
module rtcsn_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  rtcsn_pkg::job_t                   job,
  input  logic                              century_present,
  input  logic [rtcsn_pkg::REF_YEAR_W-1:0]  reference_year,
  rtcsn_out_if.source                       out_ch
);
  import rtcsn_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_ready;
  logic              s1_load;
  logic              s2_valid_r, s2_valid_nxt;
  logic              s2_ready;
  logic              s2_load;
  logic              binary;
  logic              mode_24h;
  logic [BYTE_W-1:0] sec_c, min_c, day_c, mon_c, yr_c, cen_c;
  logic [BYTE_W-1:0] hr_bcd, hr_c;
  logic [26:0]       ref_prod;
  logic [14:0]       cen_x100;
  logic [BYTE_W-1:0] sec_r, min_r, hr_r, day_r, mon_r, yr_r;
  logic [14:0]       cen_x100_r;
  logic [BYTE_W-1:0] ref_q_r;
  logic [14:0]       ref_base;
  logic [YEAR_W-1:0] ref_sum;
  logic [YEAR_W-1:0] year_c;

  function automatic logic [BYTE_W-1:0] bcd_to_bin(input logic [BYTE_W-1:0] v);
    return BYTE_W'(v[3:0]) + BYTE_W'(v[7:4]) * 8'd10;
  endfunction

  // hour mod 24 for values up to 139, by repeated subtract
  function automatic logic [BYTE_W-1:0] wrap_hour(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] t;
    t = v;
    for (int i = 0; i < 5; i++) begin
      if (t >= HOURS_PER_DAY) t = t - HOURS_PER_DAY;
    end
    return t;
  endfunction

  // pipeline flow control, stage 2 is the output register
  assign s2_ready = !s2_valid_r || out_ch.ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign job_ready = s1_ready;
  assign s1_load = job_valid && s1_ready;
  assign s2_load = s1_valid_r && s2_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s2_valid_nxt = s2_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = job_valid;
    end
    if (s2_ready) begin
      s2_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // stage 1: bcd decode, 12 to 24 hour, century products
  assign binary = job.status_b[SB_BINARY_BIT];
  assign mode_24h = job.status_b[SB_24HOUR_BIT];

  always_comb begin
    hr_bcd = {job.hour[7], 7'(job.hour[3:0]) + 7'(job.hour[6:4]) * 7'd10};
    sec_c = binary ? job.second : bcd_to_bin(job.second);
    min_c = binary ? job.minute : bcd_to_bin(job.minute);
    hr_c = binary ? job.hour : hr_bcd;
    day_c = binary ? job.day : bcd_to_bin(job.day);
    mon_c = binary ? job.month : bcd_to_bin(job.month);
    yr_c = binary ? job.year : bcd_to_bin(job.year);
    cen_c = binary ? job.century : bcd_to_bin(job.century);
    if (!mode_24h && hr_c[7]) begin
      hr_c = wrap_hour({1'b0, hr_c[6:0]} + PM_OFFSET);
    end
    cen_x100 = 15'(cen_c) * 15'(CENTURY_SPAN);
    ref_prod = 27'(reference_year) * 27'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      sec_r <= sec_c;
      min_r <= min_c;
      hr_r <= hr_c;
      day_r <= day_c;
      mon_r <= mon_c;
      yr_r <= yr_c;
      cen_x100_r <= cen_x100;
      ref_q_r <= ref_prod[RECIP_SHIFT +: BYTE_W];
    end
  end

  // stage 2: full year, from the century or the reference year
  always_comb begin
    ref_base = 15'(ref_q_r) * 15'(CENTURY_SPAN);
    ref_sum = YEAR_W'(yr_r) + YEAR_W'(ref_base);
    if (century_present) begin
      year_c = YEAR_W'(yr_r) + YEAR_W'(cen_x100_r);
    end else if (ref_sum < YEAR_W'(reference_year)) begin
      year_c = ref_sum + YEAR_W'(CENTURY_SPAN);
    end else begin
      year_c = ref_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_ch.out_second <= sec_r;
      out_ch.out_minute <= min_r;
      out_ch.out_hour <= hr_r;
      out_ch.out_day <= day_r;
      out_ch.out_month <= mon_r;
      out_ch.out_year <= year_c;
    end
  end

  assign out_ch.valid = s2_valid_r;

endmodule

// ===== design/rtc_snapshot_normalizer.sv =====
// Real-time clock snapshot normalizer. One raw register snapshot is taken per
// in_ch transaction, one per cycle with no gap needed while the queue is not
// full; a snapshot with the update flag set is dropped. A result transaction
// on out_ch appears only when two clean snapshots in a row match, giving
// binary, 24-hour time and the full year. A matching snapshot reaches
// out_ch.valid through a queue slot, the decode stage and the output
// register, which also carries the year sum. The queue holds QUEUE_DEPTH
// matched snapshots so the input side keeps running while the output is
// stalled; in_ch.ready drops only when that queue is full. cfg_ch is always
// ready; write it only while no result is outstanding.
module rtc_snapshot_normalizer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  rtcsn_in_if.sink     in_ch,
  rtcsn_out_if.source  out_ch,
  rtcsn_cfg_if.sink    cfg_ch
);
  import rtcsn_pkg::*;

  logic                  century_present_r, century_present_nxt;
  logic [REF_YEAR_W-1:0] reference_year_r, reference_year_nxt;
  logic                  cfg_write;
  logic                  queue_full;
  logic                  push_valid;
  job_t                  push_job;
  logic                  pop_valid;
  logic                  pop_ready;
  job_t                  pop_job;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  assign cfg_write = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    century_present_nxt = century_present_r;
    reference_year_nxt = reference_year_r;
    if (cfg_write) begin
      case (cfg_ch.index)
        CFG_IDX_CENTURY:  century_present_nxt = cfg_ch.data[0];
        CFG_IDX_REF_YEAR: reference_year_nxt = cfg_ch.data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      century_present_r <= 1'b0;
      reference_year_r <= REF_YEAR_RESET;
    end else begin
      century_present_r <= century_present_nxt;
      reference_year_r <= reference_year_nxt;
    end
  end

  // front: filter and match snapshots
  rtcsn_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .century_present (century_present_r),
    .queue_full      (queue_full),
    .push_valid      (push_valid),
    .push_job        (push_job)
  );

  // queue between front and back
  rtcsn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (queue_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // back: decode and output register
  rtcsn_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (pop_valid),
    .job_ready       (pop_ready),
    .job             (pop_job),
    .century_present (century_present_r),
    .reference_year  (reference_year_r),
    .out_ch          (out_ch)
  );

endmodule

// ===== tb/rtc_snapshot_normalizer_tb.sv =====
module rtc_snapshot_normalizer_tb;
  import rtcsn_pkg::*;

  localparam int ITEMS = 2000;
  localparam int PHASES = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int PM_BIT = 7;
  localparam logic [BYTE_W-1:0] HOUR_MASK = 8'h7F;
  localparam logic [BYTE_W-1:0] PM_MASK = 8'h80;

  // one raw register snapshot, busy flag in the top bit
  typedef struct packed {
    logic              busy;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] minute;
    logic [BYTE_W-1:0] hour;
    logic [BYTE_W-1:0] day;
    logic [BYTE_W-1:0] month;
    logic [BYTE_W-1:0] year;
    logic [BYTE_W-1:0] century;
    logic [BYTE_W-1:0] status_b;
  } snap_t;

  // normalized time as it leaves the block
  typedef struct packed {
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] minute;
    logic [BYTE_W-1:0] hour;
    logic [BYTE_W-1:0] day;
    logic [BYTE_W-1:0] month;
    logic [YEAR_W-1:0] year;
  } rtc_time_t;

  // directed stimulus row, want is used only when fixed is set
  typedef struct packed {
    snap_t     s;
    bit        fixed;
    rtc_time_t want;
  } row_t;

  logic clk;
  logic rst_n;

  rtcsn_in_if  in_ch();
  rtcsn_out_if out_ch();
  rtcsn_cfg_if cfg_ch();

  rtc_snapshot_normalizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the block's registers and kept snapshot
  bit                    century_on = 1'b0;
  logic [REF_YEAR_W-1:0] base_year = REF_YEAR_RESET;
  bit                    kept_ok = 1'b0;
  snap_t                 kept = '0;

  rtc_time_t pending_times[$];
  row_t      plan[$];

  int mismatch_count = 0;
  int results_seen = 0;
  int snaps_sent = 0;
  int busy_sent = 0;
  int settings_done = 0;
  int idle_cycles = 0;
  int send_burst = 0;
  int recv_burst = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic snap_t mk_snap(bit busy, logic [7:0] sec, logic [7:0] mn,
                                    logic [7:0] hr, logic [7:0] dy, logic [7:0] mo,
                                    logic [7:0] yr, logic [7:0] cen, logic [7:0] sb);
    return '{busy, sec, mn, hr, dy, mo, yr, cen, sb};
  endfunction

  function automatic rtc_time_t mk_time(logic [7:0] sec, logic [7:0] mn, logic [7:0] hr,
                                        logic [7:0] dy, logic [7:0] mo, logic [15:0] yr);
    return '{sec, mn, hr, dy, mo, yr};
  endfunction

  function automatic logic [BYTE_W-1:0] bcd_value(logic [BYTE_W-1:0] v);
    return v[3:0] + v[7:4] * 8'd10;
  endfunction

  // half valid bcd digits, half arbitrary bytes
  function automatic logic [BYTE_W-1:0] any_byte();
    if ($urandom_range(0, 1) == 0)
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    return 8'($urandom);
  endfunction

  function automatic snap_t fresh_snapshot();
    return mk_snap(1'b0, any_byte(), any_byte(), any_byte(), any_byte(), any_byte(),
                   any_byte(), any_byte(), 8'($urandom));
  endfunction

  // wait count for one transaction, with occasional stretches of none
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0)
      burst = $urandom_range(8, 40);
    return $urandom_range(0, 9);
  endfunction

  // double-read compare and normalization, returns 1 when a time comes out
  function automatic bit normalize_snapshot(input snap_t s, output rtc_time_t t);
    bit                same;
    logic [BYTE_W-1:0] sec, mn, hr, dy, mo, yr, cen;
    int unsigned       full_year;
    t = '0;
    if (s.busy)
      return 1'b0;
    same = kept_ok && s.second == kept.second && s.minute == kept.minute &&
           s.hour == kept.hour && s.day == kept.day && s.month == kept.month &&
           s.year == kept.year && (!century_on || s.century == kept.century);
    if (!same) begin
      kept_ok = 1'b1;
      kept = s;
      return 1'b0;
    end
    kept_ok = 1'b0;
    sec = s.second;
    mn = s.minute;
    hr = s.hour;
    dy = s.day;
    mo = s.month;
    yr = s.year;
    cen = s.century;
    // bcd decode, hour tens only three bits and pm flag carried along
    if (!s.status_b[SB_BINARY_BIT]) begin
      sec = bcd_value(sec);
      mn = bcd_value(mn);
      hr = (hr[3:0] + hr[6:4] * 8'd10) | (hr & PM_MASK);
      dy = bcd_value(dy);
      mo = bcd_value(mo);
      yr = bcd_value(yr);
      if (century_on)
        cen = bcd_value(cen);
    end
    // 12-hour pm to 24-hour
    if (!s.status_b[SB_24HOUR_BIT] && hr[PM_BIT])
      hr = ((hr & HOUR_MASK) + PM_OFFSET) % HOURS_PER_DAY;
    if (century_on) begin
      full_year = yr + cen * 100;
    end else begin
      full_year = yr + (base_year / 100) * 100;
      if (full_year < base_year)
        full_year += 100;
    end
    t = mk_time(sec, mn, hr, dy, mo, full_year[15:0]);
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string what, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch(what, got, want);
  endtask

  // one input transaction, entered and left at a falling edge
  task automatic send_snapshot(snap_t s, bit fixed, rtc_time_t want);
    int        gap;
    rtc_time_t t;
    bit        hit;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.update_busy = s.busy;
    in_ch.raw_second = s.second;
    in_ch.raw_minute = s.minute;
    in_ch.raw_hour = s.hour;
    in_ch.raw_day = s.day;
    in_ch.raw_month = s.month;
    in_ch.raw_year = s.year;
    in_ch.raw_century = s.century;
    in_ch.status_b = s.status_b;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    hit = normalize_snapshot(s, t);
    if (fixed || hit)
      pending_times.push_back(fixed ? want : t);
    snaps_sent++;
    if (s.busy)
      busy_sent++;
    @(negedge clk);
  endtask

  // drain results, then let any non-emitting snapshot settle
  task automatic wait_idle();
    while (pending_times.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // write both registers back to back, only while idle
  task automatic write_settings(bit cp, logic [REF_YEAR_W-1:0] yr);
    wait_idle();
    cfg_ch.valid = 1'b1;
    for (int r = 0; r < 2; r++) begin
      cfg_ch.index = (r == 0) ? CFG_IDX_CENTURY : CFG_IDX_REF_YEAR;
      cfg_ch.data = (r == 0) ? REF_YEAR_W'(cp) : yr;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (cfg_ch.index)
        CFG_IDX_CENTURY:  century_on = cfg_ch.data[0];
        CFG_IDX_REF_YEAR: base_year = cfg_ch.data;
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_ch.valid = 1'b0;
    settings_done++;
  endtask

  // result side: random stall before each transaction
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_wait(recv_burst);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin : result_check
    rtc_time_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_times.size() == 0) begin
        report_mismatch("unexpected result, second", out_ch.out_second, 0);
      end else begin
        w = pending_times.pop_front();
        check_field("second", out_ch.out_second, w.second);
        check_field("minute", out_ch.out_minute, w.minute);
        check_field("hour", out_ch.out_hour, w.hour);
        check_field("day", out_ch.out_day, w.day);
        check_field("month", out_ch.out_month, w.month);
        check_field("year", out_ch.out_year, w.year);
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    snap_t     s;
    snap_t     last;
    rtc_time_t none;
    bit        have_last;
    int        clean;
    int        pick;
    bit        phase_cp[PHASES];
    int        phase_year[PHASES];

    none = '0;
    have_last = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.update_busy = 1'b0;
    in_ch.raw_second = '0;
    in_ch.raw_minute = '0;
    in_ch.raw_hour = '0;
    in_ch.raw_day = '0;
    in_ch.raw_month = '0;
    in_ch.raw_year = '0;
    in_ch.raw_century = '0;
    in_ch.status_b = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_IDX_CENTURY;
    cfg_ch.data = '0;

    phase_cp = '{0, 0, 1, 1, 0, 1, 0, 1, 0};
    phase_year = '{0, 9999, 0, 9999, $urandom_range(0, 9999), $urandom_range(0, 9999),
                   $urandom_range(0, 9999), $urandom_range(0, 9999), 2015};

    // directed rows under reset settings: no century, reference year 2015
    plan.push_back('{mk_snap(1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                     0, none});
    plan.push_back('{mk_snap(0, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h20, 8'h02),
                     0, none});
    plan.push_back('{mk_snap(0, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h20, 8'h02),
                     1, mk_time(59, 59, 23, 31, 12, 2099)});
    // busy read between two matching reads is ignored
    plan.push_back('{mk_snap(1, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h20, 8'h02),
                     0, none});
    plan.push_back('{mk_snap(0, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h20, 8'h02),
                     0, none});
    plan.push_back('{mk_snap(1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                     0, none});
    plan.push_back('{mk_snap(0, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h20, 8'h02),
                     1, mk_time(59, 59, 23, 31, 12, 2099)});
    // all zero, year below reference rolls to next century
    plan.push_back('{mk_snap(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
    plan.push_back('{mk_snap(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_time(0, 0, 0, 0, 0, 2100)});
    // 12 pm in 12-hour bcd wraps to hour 0, year equal to reference
    plan.push_back('{mk_snap(0, 8'h30, 8'h15, 8'h92, 8'h01, 8'h01, 8'h15, 0, 8'h00),
                     0, none});
    plan.push_back('{mk_snap(0, 8'h30, 8'h15, 8'h92, 8'h01, 8'h01, 8'h15, 0, 8'h00),
                     1, mk_time(30, 15, 0, 1, 1, 2015)});
    // binary 24-hour, all ones pass straight through
    plan.push_back('{mk_snap(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h06),
                     0, none});
    plan.push_back('{mk_snap(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h06),
                     1, mk_time(255, 255, 255, 255, 255, 2255)});
    // binary 12-hour, 11 pm
    plan.push_back('{mk_snap(0, 5, 6, 8'h8B, 7, 8, 14, 0, 8'h04), 0, none});
    plan.push_back('{mk_snap(0, 5, 6, 8'h8B, 7, 8, 14, 0, 8'h04),
                     1, mk_time(5, 6, 23, 7, 8, 2114)});
    // invalid bcd digits in every field
    plan.push_back('{mk_snap(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00),
                     0, none});
    plan.push_back('{mk_snap(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00),
                     0, none});
    // a differing read replaces the kept one
    plan.push_back('{mk_snap(0, 8'h10, 8'h20, 8'h08, 8'h15, 8'h06, 8'h42, 8'h20, 8'h02),
                     0, none});
    plan.push_back('{mk_snap(0, 8'h11, 8'h20, 8'h08, 8'h15, 8'h06, 8'h42, 8'h20, 8'h02),
                     0, none});
    plan.push_back('{mk_snap(0, 8'h11, 8'h20, 8'h08, 8'h15, 8'h06, 8'h42, 8'h20, 8'h02),
                     0, none});
    // century ignored when absent, status b taken from the second read
    plan.push_back('{mk_snap(0, 8'h45, 8'h03, 8'h87, 8'h28, 8'h02, 8'h00, 8'h19, 8'h06),
                     0, none});
    plan.push_back('{mk_snap(0, 8'h45, 8'h03, 8'h87, 8'h28, 8'h02, 8'h00, 8'h20, 8'h00),
                     0, none});

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i])
      send_snapshot(plan[i].s, plan[i].fixed, plan[i].want);

    // random reads under each register setting
    for (int p = 0; p < PHASES; p++) begin
      in_ch.valid = 1'b0;
      write_settings(phase_cp[p], REF_YEAR_W'(phase_year[p]));
      clean = 0;
      while (clean < ITEMS / PHASES) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          s = fresh_snapshot();
          s.busy = 1'b1;
        end else if (pick < 55 && have_last) begin
          // stable re-read, status b and sometimes century may move
          s = last;
          s.status_b = 8'($urandom);
          if ($urandom_range(0, 3) == 0)
            s.century = any_byte();
        end else if (pick < 62 && have_last) begin
          // re-read caught mid-change: at most one bit off, which may be the busy flag
          s = last;
          s[$urandom_range(8, 71)] ^= 1'b1;
        end else begin
          s = fresh_snapshot();
        end
        if (!s.busy) begin
          last = s;
          have_last = 1'b1;
          clean++;
        end
        send_snapshot(s, 1'b0, none);
      end
    end

    in_ch.valid = 1'b0;
    wait_idle();

    $display("sent %0d snapshots (%0d during update), checked %0d normalized times",
             snaps_sent, busy_sent, results_seen);
    $display("covered %0d register settings, century register on and off, base year 0..9999",
             settings_done);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
